/* design/dgwm_pkg.sv */
// shared types and constants for the graphical walk block
package dgwm_pkg;

    localparam int CNT_W   = 21;
    localparam int WX_W    = 36;
    localparam int WY_W    = 37;
    localparam int SX_W    = 56;
    localparam int SY_W    = 57;
    localparam int DQ_W    = 58;
    localparam int ACC_W   = 75;
    localparam int MB_W    = 37;
    localparam int RAD_W   = 76;
    localparam int ROOT_W  = 38;
    localparam int REM_W   = 41;
    localparam int STEP_W  = 6;

    localparam logic [63:0] SQ3H_Q32 = 64'd3719550771;
    localparam logic [63:0] SQ3_Q32  = 64'd7439101541;

    localparam logic [7:0] CASE_MASK = 8'hDF;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_G    = 8'h47;
    localparam logic [7:0] CHAR_T    = 8'h54;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic KIND_BASE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd58;
    localparam logic [STEP_W-1:0] SQX_STEPS  = 6'd36;
    localparam logic [STEP_W-1:0] SQY_STEPS  = 6'd37;
    localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd38;
    localparam logic [STEP_W-1:0] RES_STEPS  = 6'd21;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_BASE,
        CMD_END_START,
        CMD_DIV_STEP,
        CMD_DIV_LOAD_Y,
        CMD_MUL_LOAD_X,
        CMD_MUL_LOAD_Y,
        CMD_MUL_STEP,
        CMD_SQRT_LOAD,
        CMD_SQRT_STEP,
        CMD_MUL_LOAD_GC,
        CMD_MUL_LOAD_AT,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctrl_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

/* design/dgwm_ctrl.sv */
// sequencer for the summary computation and input handshake
module dgwm_ctrl
    import dgwm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    action,
    input  status_t status,
    output ctrl_t   ctrl
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIVX, S_DIVY, S_SQX, S_SQY, S_SQRT, S_RGC, S_RAT, S_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE) && !status.out_busy;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 6'd1;
        ctrl.cmd   = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_valid && in_ready)
                begin
                    if (action == ACT_END)
                    begin
                        ctrl.cmd   = CMD_END_START;
                        state_next = S_DIVX;
                    end
                    else
                    begin
                        ctrl.cmd = CMD_BASE;
                    end
                end
            end
            S_DIVX:
            begin
                if (cnt_reg < DIV_STEPS)
                    ctrl.cmd = CMD_DIV_STEP;
                else
                begin
                    ctrl.cmd   = CMD_DIV_LOAD_Y;
                    cnt_next   = '0;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (cnt_reg < DIV_STEPS)
                    ctrl.cmd = CMD_DIV_STEP;
                else
                begin
                    ctrl.cmd   = CMD_MUL_LOAD_X;
                    cnt_next   = '0;
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                if (cnt_reg < SQX_STEPS)
                    ctrl.cmd = CMD_MUL_STEP;
                else
                begin
                    ctrl.cmd   = CMD_MUL_LOAD_Y;
                    cnt_next   = '0;
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (cnt_reg < SQY_STEPS)
                    ctrl.cmd = CMD_MUL_STEP;
                else
                begin
                    ctrl.cmd   = CMD_SQRT_LOAD;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (cnt_reg < SQRT_STEPS)
                    ctrl.cmd = CMD_SQRT_STEP;
                else
                begin
                    ctrl.cmd   = CMD_MUL_LOAD_GC;
                    cnt_next   = '0;
                    state_next = S_RGC;
                end
            end
            S_RGC:
            begin
                if (cnt_reg < RES_STEPS)
                    ctrl.cmd = CMD_MUL_STEP;
                else
                begin
                    ctrl.cmd   = CMD_MUL_LOAD_AT;
                    cnt_next   = '0;
                    state_next = S_RAT;
                end
            end
            S_RAT:
            begin
                if (cnt_reg < RES_STEPS)
                    ctrl.cmd = CMD_MUL_STEP;
                else
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cnt_next = '0;
                if (!status.out_busy)
                begin
                    ctrl.cmd   = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                cnt_next   = '0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* design/dgwm_datapath.sv */
// walk state, serial divider, multiplier, square root and output register
module dgwm_datapath
    import dgwm_pkg::*;
#(
    parameter int MAX_LEN   = 1048576,
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    output status_t            status,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [1:0]         base_code,
    output logic [CNT_W-1:0]   position,
    output logic [CNT_W-1:0]   count_adenine,
    output logic [CNT_W-1:0]   count_cytosine,
    output logic [CNT_W-1:0]   count_guanine,
    output logic [CNT_W-1:0]   count_thymine,
    output logic [WX_W-1:0]    mean_x,
    output logic signed [WY_W-1:0] mean_y,
    output logic [WX_W-1:0]    gyration_radius,
    output logic [WX_W-1:0]    resultant_x,
    output logic [WX_W-1:0]    resultant_y
);

    localparam logic [63:0] QCOS  =
        (SQ3H_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] QSQ3  =
        (SQ3_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] QHALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] KPROD = QCOS * QSQ3;
    localparam logic [CNT_W-1:0] MAXL = CNT_W'(MAX_LEN);

    logic [WX_W-1:0]   walk_x_reg;
    logic [WY_W-1:0]   walk_y_reg;
    logic [SX_W-1:0]   sum_x_reg;
    logic [SY_W-1:0]   sum_y_reg;
    logic [CNT_W-1:0]  cnt_reg [4];
    logic [DQ_W-1:0]   dq_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic              neg_reg;
    logic [WX_W-1:0]   mx_reg;
    logic [WY_W-1:0]   mymag_reg;
    logic [ACC_W-1:0]  ma_reg, acc_reg;
    logic [MB_W-1:0]   mb_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  srem_reg;
    logic [WX_W-1:0]   gr_reg, xr_reg;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [1:0]        base_code_reg;
    logic [CNT_W-1:0]  position_reg;
    logic [CNT_W-1:0]  count_adenine_reg;
    logic [CNT_W-1:0]  count_cytosine_reg;
    logic [CNT_W-1:0]  count_guanine_reg;
    logic [CNT_W-1:0]  count_thymine_reg;
    logic [WX_W-1:0]   mean_x_reg;
    logic [WY_W-1:0]   mean_y_reg;
    logic [WX_W-1:0]   gyration_radius_reg;
    logic [WX_W-1:0]   resultant_x_reg;
    logic [WX_W-1:0]   resultant_y_reg;

    logic [CNT_W-1:0]  total, at_cnt, gc_cnt;
    logic [7:0]        uc;
    logic              is_base;
    logic              base_take;
    logic              out_load;
    logic [1:0]        code;
    logic [WX_W-1:0]   dx, wx_new;
    logic [WY_W-1:0]   dy, wy_new;
    logic [SY_W-1:0]   mag_y;
    logic [CNT_W:0]    div_sh;
    logic              div_ge;
    logic [REM_W-1:0]  sq_sh, sq_trial;
    logic              sq_ge;
    logic [DQ_W-1:0]   res_sum;
    logic [WY_W-1:0]   my_final;

    assign total  = cnt_reg[0] + cnt_reg[1] + cnt_reg[2] + cnt_reg[3];
    assign at_cnt = cnt_reg[0] + cnt_reg[3];
    assign gc_cnt = cnt_reg[1] + cnt_reg[2];
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign base_code       = base_code_reg;
    assign position        = position_reg;
    assign count_adenine   = count_adenine_reg;
    assign count_cytosine  = count_cytosine_reg;
    assign count_guanine   = count_guanine_reg;
    assign count_thymine   = count_thymine_reg;
    assign mean_x          = mean_x_reg;
    assign mean_y          = mean_y_reg;
    assign gyration_radius = gyration_radius_reg;
    assign resultant_x     = resultant_x_reg;
    assign resultant_y     = resultant_y_reg;

    always_comb
    begin
        uc      = char_code & CASE_MASK;
        is_base = 1'b1;
        code    = BASE_A;
        case (uc)
            CHAR_A:  code = BASE_A;
            CHAR_C:  code = BASE_C;
            CHAR_G:  code = BASE_G;
            CHAR_T:  code = BASE_T;
            default: is_base = 1'b0;
        endcase
        case (code)
            BASE_A:
            begin
                dx = WX_W'(QHALF);
                dy = -WY_W'(QCOS);
            end
            BASE_C:
            begin
                dx = WX_W'(QCOS);
                dy = WY_W'(QHALF);
            end
            BASE_G:
            begin
                dx = WX_W'(QCOS);
                dy = -WY_W'(QHALF);
            end
            default:
            begin
                dx = WX_W'(QHALF);
                dy = WY_W'(QCOS);
            end
        endcase
    end

    assign base_take = (ctrl.cmd == CMD_BASE) && is_base && (total < MAXL);
    assign out_load  = base_take || (ctrl.cmd == CMD_FINISH);

    assign wx_new = walk_x_reg + dx;
    assign wy_new = walk_y_reg + dy;
    assign mag_y  = sum_y_reg[SY_W-1] ? -sum_y_reg : sum_y_reg;

    // restoring division, one quotient bit a cycle
    assign div_sh = {rem_reg, dq_reg[DQ_W-1]};
    assign div_ge = div_sh >= {1'b0, total};

    // digit-by-digit square root, two radicand bits a cycle
    assign sq_sh    = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    assign res_sum  = (DQ_W'(at_cnt) << (FRAC_BITS - 1))
                    + ((DQ_W'(acc_reg) + DQ_W'(QHALF)) >> FRAC_BITS);
    assign my_final = neg_reg ? -mymag_reg : mymag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            for (int i = 0; i < 4; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (ctrl.cmd)
                CMD_BASE:
                begin
                    if (base_take)
                    begin
                        cnt_reg[code] <= cnt_reg[code] + 21'd1;
                        walk_x_reg    <= wx_new;
                        walk_y_reg    <= wy_new;
                        sum_x_reg     <= sum_x_reg + SX_W'(wx_new);
                        sum_y_reg     <= sum_y_reg + {{(SY_W-WY_W){wy_new[WY_W-1]}}, wy_new};
                    end
                end
                CMD_FINISH:
                begin
                    walk_x_reg <= '0;
                    walk_y_reg <= '0;
                    sum_x_reg  <= '0;
                    sum_y_reg  <= '0;
                    for (int i = 0; i < 4; i++)
                        cnt_reg[i] <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // arithmetic and result registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            CMD_BASE:
            begin
                kind_reg            <= KIND_BASE;
                base_code_reg       <= code;
                position_reg        <= total + 21'd1;
                count_adenine_reg   <= '0;
                count_cytosine_reg  <= '0;
                count_guanine_reg   <= '0;
                count_thymine_reg   <= '0;
                mean_x_reg          <= '0;
                mean_y_reg          <= '0;
                gyration_radius_reg <= '0;
                resultant_x_reg     <= '0;
                resultant_y_reg     <= '0;
            end
            CMD_END_START:
            begin
                dq_reg  <= DQ_W'(sum_x_reg) + DQ_W'(total >> 1);
                rem_reg <= '0;
                neg_reg <= sum_y_reg[SY_W-1];
            end
            CMD_DIV_STEP:
            begin
                rem_reg <= div_ge ? CNT_W'(div_sh - {1'b0, total}) : div_sh[CNT_W-1:0];
                dq_reg  <= {dq_reg[DQ_W-2:0], div_ge};
            end
            CMD_DIV_LOAD_Y:
            begin
                mx_reg  <= (total == '0) ? '0 : dq_reg[WX_W-1:0];
                dq_reg  <= DQ_W'(mag_y) + DQ_W'(total >> 1);
                rem_reg <= '0;
            end
            CMD_MUL_LOAD_X:
            begin
                mymag_reg <= (total == '0) ? '0 : dq_reg[WY_W-1:0];
                ma_reg    <= ACC_W'(mx_reg);
                mb_reg    <= MB_W'(mx_reg);
                acc_reg   <= '0;
            end
            CMD_MUL_LOAD_Y:
            begin
                ma_reg <= ACC_W'(mymag_reg);
                mb_reg <= mymag_reg;
            end
            CMD_MUL_STEP:
            begin
                if (mb_reg[0])
                    acc_reg <= acc_reg + ma_reg;
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            CMD_SQRT_LOAD:
            begin
                rad_reg  <= RAD_W'(acc_reg);
                root_reg <= '0;
                srem_reg <= '0;
            end
            CMD_SQRT_STEP:
            begin
                srem_reg <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                rad_reg  <= rad_reg << 2;
            end
            CMD_MUL_LOAD_GC:
            begin
                gr_reg  <= root_reg[WX_W-1:0];
                ma_reg  <= ACC_W'(KPROD);
                mb_reg  <= MB_W'(gc_cnt);
                acc_reg <= '0;
            end
            CMD_MUL_LOAD_AT:
            begin
                // resultant x uses the A+T half term with the G+C product
                xr_reg  <= res_sum[WX_W:1];
                ma_reg  <= ACC_W'(KPROD);
                mb_reg  <= MB_W'(at_cnt);
                acc_reg <= '0;
            end
            CMD_FINISH:
            begin
                kind_reg            <= KIND_SUMMARY;
                base_code_reg       <= '0;
                position_reg        <= total;
                count_adenine_reg   <= cnt_reg[0];
                count_cytosine_reg  <= cnt_reg[1];
                count_guanine_reg   <= cnt_reg[2];
                count_thymine_reg   <= cnt_reg[3];
                mean_x_reg          <= mx_reg;
                mean_y_reg          <= my_final;
                gyration_radius_reg <= gr_reg;
                resultant_x_reg     <= xr_reg;
                resultant_y_reg     <= WX_W'(((DQ_W'(gc_cnt) << (FRAC_BITS - 1))
                                      + ((DQ_W'(acc_reg) + DQ_W'(QHALF)) >> FRAC_BITS)) >> 1);
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* design/dna_graphical_walk_moments.sv */
// top level of the dna graphical walk with running moments
//
// in channel: in_valid/in_ready with action and char_code; action low carries
// a character, action high ends the sequence. out channel: out_valid/out_ready
// with the record fields.
// a base character (a, c, g, t in either case) gives one position record that
// is valid the cycle after it is taken; other bytes give nothing. bases past
// MAX_LEN are dropped.
// a character word is taken while the sequencer is idle and the output
// register is empty or being drained.
// an end word runs a serial sequencer: two divisions for the means, a
// shift-add pass summing the squares of both means, a square root, two resultant
// products and a finish step that waits for the output register to free and
// loads the summary word; the walk state then clears.
// reset clears the walk, the sums, the counts and the output valid.
// while the receiver stalls the output word holds and no new word is taken.
module dna_graphical_walk_moments
    import dgwm_pkg::*;
#(
    parameter int MAX_LEN   = 1048576,
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [1:0]         base_code,
    output logic [CNT_W-1:0]   position,
    output logic [CNT_W-1:0]   count_adenine,
    output logic [CNT_W-1:0]   count_cytosine,
    output logic [CNT_W-1:0]   count_guanine,
    output logic [CNT_W-1:0]   count_thymine,
    output logic [WX_W-1:0]    mean_x,
    output logic signed [WY_W-1:0] mean_y,
    output logic [WX_W-1:0]    gyration_radius,
    output logic [WX_W-1:0]    resultant_x,
    output logic [WX_W-1:0]    resultant_y
);

    ctrl_t   ctrl;
    status_t status;

    dgwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .ctrl     (ctrl)
    );

    dgwm_datapath #(
        .MAX_LEN   (MAX_LEN),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .status          (status),
        .char_code       (char_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .base_code       (base_code),
        .position        (position),
        .count_adenine   (count_adenine),
        .count_cytosine  (count_cytosine),
        .count_guanine   (count_guanine),
        .count_thymine   (count_thymine),
        .mean_x          (mean_x),
        .mean_y          (mean_y),
        .gyration_radius (gyration_radius),
        .resultant_x     (resultant_x),
        .resultant_y     (resultant_y)
    );

endmodule
